[rtl/teq_pkg.sv]
package teq_pkg;

  // Operation codes carried in the op field of an input word.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Result kinds.
  localparam logic KIND_RELEASED = 1'b0;
  localparam logic KIND_DROPPED  = 1'b1;

  localparam int TIME_W = 31;

  // One input word.
  typedef struct packed {
    logic [1:0]         op;
    logic [TIME_W-1:0]  now;
    logic [15:0]        time_offset;
    logic [9:0]         emitter;
    logic [2:0]         channel_id;
    logic [9:0]         sound_id;
    logic [8:0]         volume;
    logic [15:0]        attenuation;
    logic               has_position;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic               kind;
    logic [9:0]         out_emitter;
    logic [2:0]         out_channel;
    logic [9:0]         out_sound;
    logic [8:0]         out_volume;
    logic [15:0]        out_attenuation;
    logic               out_has_position;
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic signed [23:0] out_z;
    logic [TIME_W-1:0]  start_time;
    logic               last;
  } out_word_t;

  // One stored event in the pool.
  typedef struct packed {
    logic [9:0]         emitter;
    logic [2:0]         channel;
    logic [9:0]         sound;
    logic [8:0]         volume;
    logic [15:0]        attenuation;
    logic               has_pos;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [TIME_W-1:0]  start;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clear;
    logic alloc;
    logic write_entry;
    logic walk_step;
    logic link_new;
    logic link_prev;
    logic pop_head;
    logic emit_drop;
    logic emit_held;
    logic emit_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic head_v;
    logic cur_v;
    logic rdn_v;
    logic less;
    logic due;
    logic held_v;
    logic out_free;
  } status_t;

  // Builds a result word from a stored event.
  function automatic out_word_t to_out(entry_t ent, logic kind, logic last);
    out_word_t w;
    w.kind             = kind;
    w.out_emitter      = ent.emitter;
    w.out_channel      = ent.channel;
    w.out_sound        = ent.sound;
    w.out_volume       = ent.volume;
    w.out_attenuation  = ent.attenuation;
    w.out_has_position = ent.has_pos;
    w.out_x            = ent.x;
    w.out_y            = ent.y;
    w.out_z            = ent.z;
    w.start_time       = ent.start;
    w.last             = last;
    return w;
  endfunction

endpackage

[rtl/teq_datapath.sv]
module teq_datapath #(
  parameter int POOL_ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  teq_pkg::in_word_t   in_word,
  input  teq_pkg::cmd_t       cmd,
  output teq_pkg::status_t    st,
  input  logic                out_stall,
  output logic                out_valid,
  output teq_pkg::out_word_t  out_word
);

  localparam int IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int CW = $clog2(POOL_ENTRIES + 1);

  // Pool storage: event data, next links (valid bit on top) and the stack of freed entries.
  teq_pkg::entry_t ent_mem [POOL_ENTRIES];
  logic [IW:0]     nxt_mem [POOL_ENTRIES];
  logic [IW-1:0]   fstack  [POOL_ENTRIES];

  teq_pkg::in_word_t       item;
  logic [teq_pkg::TIME_W-1:0] start;
  teq_pkg::entry_t         new_entry;
  teq_pkg::entry_t         rd;
  teq_pkg::entry_t         held;
  logic [IW:0]             rdn;
  logic [IW-1:0]           fs_rd;
  logic [IW-1:0]           e;
  logic [IW-1:0]           head;
  logic                    head_v;
  logic [IW-1:0]           cur;
  logic                    cur_v;
  logic [IW-1:0]           prv;
  logic                    prv_v;
  logic                    held_v;
  logic [CW-1:0]           fill;
  logic [CW-1:0]           sp;
  logic [CW-1:0]           sp_m1;
  logic [CW-1:0]           count;
  logic [31:0]             sum;
  logic [teq_pkg::TIME_W-1:0] start_sat;

  // Saturating start time of the incoming word.
  assign sum       = {1'b0, in_word.now} + {16'd0, in_word.time_offset};
  assign start_sat = sum[31] ? '1 : sum[teq_pkg::TIME_W-1:0];
  assign sp_m1     = sp - CW'(1);

  // Event as it is stored; the position reads as zero without a fixed position.
  always_comb begin
    new_entry.emitter     = item.emitter;
    new_entry.channel     = item.channel_id;
    new_entry.sound       = item.sound_id;
    new_entry.volume      = item.volume;
    new_entry.attenuation = item.attenuation;
    new_entry.has_pos     = item.has_position;
    new_entry.x           = item.has_position ? item.pos_x : '0;
    new_entry.y           = item.has_position ? item.pos_y : '0;
    new_entry.z           = item.has_position ? item.pos_z : '0;
    new_entry.start       = start;
  end

  // Memories, with registered reads at the walk pointer and the top of the free stack.
  always_ff @(posedge clk) begin
    rd    <= ent_mem[cur];
    rdn   <= nxt_mem[cur];
    fs_rd <= fstack[sp_m1[IW-1:0]];
    if (cmd.write_entry) begin
      ent_mem[e] <= new_entry;
    end
    if (cmd.link_new) begin
      nxt_mem[e] <= {cur_v, cur};
    end
    if (cmd.link_prev && prv_v) begin
      nxt_mem[prv] <= {1'b1, e};
    end
    if (cmd.pop_head) begin
      fstack[sp[IW-1:0]] <= cur;
    end
  end

  // List pointers, counters and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      sp        <= '0;
      count     <= '0;
      head_v    <= 1'b0;
      cur_v     <= 1'b0;
      prv_v     <= 1'b0;
      held_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !cmd.emit_drop && !cmd.emit_held) begin
        out_valid <= 1'b0;
      end
      if (cmd.accept) begin
        item  <= in_word;
        start <= start_sat;
        cur   <= head;
        cur_v <= head_v;
        prv_v <= 1'b0;
      end
      if (cmd.clear) begin
        fill   <= '0;
        sp     <= '0;
        count  <= '0;
        head_v <= 1'b0;
      end
      if (cmd.alloc) begin
        count <= count + CW'(1);
        if (sp != '0) begin
          e  <= fs_rd;
          sp <= sp_m1;
        end else begin
          e    <= fill[IW-1:0];
          fill <= fill + CW'(1);
        end
      end
      if (cmd.walk_step) begin
        prv   <= cur;
        prv_v <= 1'b1;
        cur   <= rdn[IW-1:0];
        cur_v <= rdn[IW];
      end
      if (cmd.link_prev && !prv_v) begin
        head   <= e;
        head_v <= 1'b1;
      end
      if (cmd.pop_head) begin
        sp     <= sp + CW'(1);
        count  <= count - CW'(1);
        head   <= rdn[IW-1:0];
        head_v <= rdn[IW];
        cur    <= rdn[IW-1:0];
        cur_v  <= rdn[IW];
        held   <= rd;
        held_v <= 1'b1;
      end
      if (cmd.emit_drop) begin
        out_valid <= 1'b1;
        out_word  <= teq_pkg::to_out(new_entry, teq_pkg::KIND_DROPPED, 1'b1);
      end
      if (cmd.emit_held) begin
        out_valid <= 1'b1;
        out_word  <= teq_pkg::to_out(held, teq_pkg::KIND_RELEASED, cmd.emit_last);
        if (cmd.emit_last) begin
          held_v <= 1'b0;
        end
      end
    end
  end

  // Status back to the controller.
  assign st.full     = (count == CW'(POOL_ENTRIES));
  assign st.head_v   = head_v;
  assign st.cur_v    = cur_v;
  assign st.rdn_v    = rdn[IW];
  assign st.less     = (rd.start < start);
  assign st.due      = (rd.start <= item.now);
  assign st.held_v   = held_v;
  assign st.out_free = !out_valid || !out_stall;

  // Every entry ever handed out is either pending or on the free stack.
  a_pool_balance: assert property (@(posedge clk) disable iff (rst)
    ((CW+1)'(count) + (CW+1)'(sp)) == (CW+1)'(fill))
    else $error("pool bookkeeping out of balance");

  // An entry is released only when its start time has come.
  a_pop_due: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_head |-> st.due)
    else $error("entry released before its start time");

  // No allocation from a full pool.
  a_alloc_room: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |-> !st.full)
    else $error("allocation from a full pool");

endmodule

[rtl/teq_ctrl.sv]
module teq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        op,
  output logic              in_stall,
  input  teq_pkg::status_t  st,
  output teq_pkg::cmd_t     cmd
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_DROP      = 11'b000_0000_0010,
    S_ALLOC     = 11'b000_0000_0100,
    S_WRITE     = 11'b000_0000_1000,
    S_WALK_RD   = 11'b000_0001_0000,
    S_WALK_CMP  = 11'b000_0010_0000,
    S_LINK_NEW  = 11'b000_0100_0000,
    S_LINK_PREV = 11'b000_1000_0000,
    S_TICK_RD   = 11'b001_0000_0000,
    S_TICK_CMP  = 11'b010_0000_0000,
    S_TICK_LAST = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (op)
            teq_pkg::OP_INSERT: state_next = st.full ? S_DROP : S_ALLOC;
            teq_pkg::OP_TICK:   state_next = st.head_v ? S_TICK_RD : S_IDLE;
            teq_pkg::OP_CLEAR:  cmd.clear = 1'b1;
            default:            state_next = S_IDLE;
          endcase
        end
      end
      S_DROP: begin
        if (st.out_free) begin
          cmd.emit_drop = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_ALLOC: begin
        cmd.alloc  = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.write_entry = 1'b1;
        state_next      = st.cur_v ? S_WALK_RD : S_LINK_NEW;
      end
      S_WALK_RD: begin
        state_next = S_WALK_CMP;
      end
      S_WALK_CMP: begin
        if (st.less) begin
          cmd.walk_step = 1'b1;
          state_next    = st.rdn_v ? S_WALK_RD : S_LINK_NEW;
        end else begin
          state_next = S_LINK_NEW;
        end
      end
      S_LINK_NEW: begin
        cmd.link_new = 1'b1;
        state_next   = S_LINK_PREV;
      end
      S_LINK_PREV: begin
        cmd.link_prev = 1'b1;
        state_next    = S_IDLE;
      end
      S_TICK_RD: begin
        state_next = S_TICK_CMP;
      end
      S_TICK_CMP: begin
        // A due entry is held back until the next one shows whether it is the last.
        if (st.due) begin
          if (!st.held_v || st.out_free) begin
            cmd.pop_head  = 1'b1;
            cmd.emit_held = st.held_v;
            state_next    = st.rdn_v ? S_TICK_RD : S_TICK_LAST;
          end
        end else begin
          state_next = st.held_v ? S_TICK_LAST : S_IDLE;
        end
      end
      S_TICK_LAST: begin
        if (st.out_free) begin
          cmd.emit_held = 1'b1;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A held release word never outlives its tick.
  a_idle_no_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !st.held_v)
    else $error("held release word left behind");

  // Emitting the last word of a tick returns the controller to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_last |=> (state == S_IDLE))
    else $error("last word emitted mid tick");

  // Only an insert word leads into allocation.
  a_alloc_from_insert: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALLOC) |-> ($past(op) == teq_pkg::OP_INSERT))
    else $error("allocation without insert");

endmodule

[rtl/timed_event_queue.sv]
// Timed event queue: delayed sound events kept in start-time order.
// Input channel in_valid/in_stall/in_word: op 0 inserts an event starting at
// now + time_offset (saturated), op 1 releases every pending event whose start
// time is not after now, op 2 empties the queue, op 3 is ignored.
// Output channel out_valid/out_stall/out_word: one word per released event,
// last set on the final word of a tick; an insert into a full pool gives one
// dropped word (kind 1, last 1) instead.
// An insert walks the list, one memory read per step, and compares against
// each pending entry that starts earlier and the first that does not. A tick
// reads and compares the pending events from the head, one read per step,
// releasing each due one. A tick on an empty queue, a clear or an ignored op
// is done without leaving idle.
// The queue takes one input word at a time; in_stall is high while a word is
// being worked on. A finished result sits in the output register, so a new
// word is taken while it waits. When the receiver stalls, the block holds
// its word and pauses before the next release.
// Reset (rst, synchronous) empties the queue and the output; no sweep of the
// pool memory is needed.
module timed_event_queue #(
  parameter int POOL_ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  teq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output teq_pkg::out_word_t out_word
);

  teq_pkg::cmd_t    cmd;
  teq_pkg::status_t st;

  // Sequencing of insert, tick and clear.
  teq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (in_word.op),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Pool memories, list pointers and the output register.
  teq_datapath #(
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cmd       (cmd),
    .st        (st),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

[tb/sv/timed_event_queue_checker.sv]
module timed_event_queue_checker #(
  parameter int POOL_ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  teq_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  teq_pkg::out_word_t out_word,
  output int                 fail_count,
  output int                 pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [teq_pkg::TIME_W-1:0] TIME_TOP = {teq_pkg::TIME_W{1'b1}};

  // The predictor keeps the pending events as a queue sorted by start time.
  teq_pkg::entry_t    sched_q[$];
  teq_pkg::out_word_t expected_q[$];

  assign pending_results = expected_q.size();

  function automatic teq_pkg::entry_t make_event(teq_pkg::in_word_t w);
    teq_pkg::entry_t ev;
    logic [31:0]     sum;
    sum = {1'b0, w.now} + {16'd0, w.time_offset};
    ev.emitter     = w.emitter;
    ev.channel     = w.channel_id;
    ev.sound       = w.sound_id;
    ev.volume      = w.volume;
    ev.attenuation = w.attenuation;
    ev.has_pos     = w.has_position;
    ev.x           = w.has_position ? w.pos_x : '0;
    ev.y           = w.has_position ? w.pos_y : '0;
    ev.z           = w.has_position ? w.pos_z : '0;
    ev.start       = sum[31] ? TIME_TOP : sum[teq_pkg::TIME_W-1:0];
    return ev;
  endfunction

  function automatic teq_pkg::out_word_t word_of(teq_pkg::entry_t ev, logic kind, logic last);
    teq_pkg::out_word_t r;
    r.kind = kind; r.out_emitter = ev.emitter; r.out_channel = ev.channel;
    r.out_sound = ev.sound; r.out_volume = ev.volume;
    r.out_attenuation = ev.attenuation; r.out_has_position = ev.has_pos;
    r.out_x = ev.x; r.out_y = ev.y; r.out_z = ev.z;
    r.start_time = ev.start; r.last = last;
    return r;
  endfunction

  // Apply one accepted input word to the schedule and queue its results.
  task automatic apply_word(teq_pkg::in_word_t w);
    teq_pkg::entry_t ev;
    int              pos;
    int              n;
    case (w.op)
      teq_pkg::OP_INSERT: begin
        ev = make_event(w);
        if (sched_q.size() >= POOL_ENTRIES) begin
          expected_q.push_back(word_of(ev, teq_pkg::KIND_DROPPED, 1'b1));
        end else begin
          // A new event goes ahead of others with the same start time.
          pos = 0;
          while (pos < sched_q.size() && sched_q[pos].start < ev.start) pos++;
          sched_q.insert(pos, ev);
        end
      end
      teq_pkg::OP_TICK: begin
        n = 0;
        while (sched_q.size() > 0 && sched_q[0].start <= w.now) begin
          expected_q.push_back(word_of(sched_q.pop_front(), teq_pkg::KIND_RELEASED, 1'b0));
          n++;
        end
        if (n > 0) expected_q[expected_q.size()-1].last = 1'b1;
      end
      teq_pkg::OP_CLEAR: sched_q.delete();
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    teq_pkg::out_word_t want;
    if (rst) begin
      sched_q.delete();
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) apply_word(in_word);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %p", out_word);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== out_word) begin
            if (fail_count < 10) $display("mismatch: expected %p, got %p", want, out_word);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  // Leftover expectations are counted as failures by the top at the end.
endmodule

[tb/sv/timed_event_queue_tb.sv]
module timed_event_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL = 64;
  localparam int WATCH_LIMIT = 20000;
  localparam int TW = teq_pkg::TIME_W;
  localparam int IN_W = $bits(teq_pkg::in_word_t);
  // Op code with no function; the block must ignore it.
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  teq_pkg::in_word_t  in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  teq_pkg::out_word_t out_word;
  int                 fail_count;
  int                 pending_results;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 1'b0;
  int  quiet_cycles = 0;
  logic [TW-1:0] clock_ms = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  timed_event_queue #(.POOL_ENTRIES(POOL)) i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  timed_event_queue_checker #(.POOL_ENTRIES(POOL)) i_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  // Receiver stall, decided at each falling edge.
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog on cycles with no accepted word on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCH_LIMIT) begin
      $display("timed_event_queue verification failed");
      $finish;
    end
  end

  // Offer one word and hold it until it is taken; valid drops only for idle cycles.
  task automatic send_word(teq_pkg::in_word_t w);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic teq_pkg::in_word_t rand_event(logic [TW-1:0] t, logic [15:0] offs);
    teq_pkg::in_word_t w;
    w.op = teq_pkg::OP_INSERT;
    w.now = t;
    w.time_offset = offs;
    w.emitter = 10'($urandom);
    w.channel_id = 3'($urandom);
    w.sound_id = 10'($urandom);
    w.volume = 9'($urandom_range(511));
    w.attenuation = 16'($urandom);
    w.has_position = 1'($urandom);
    w.pos_x = 24'($urandom);
    w.pos_y = 24'($urandom);
    w.pos_z = 24'($urandom);
    return w;
  endfunction

  function automatic teq_pkg::in_word_t ctrl_word(logic [1:0] op, logic [TW-1:0] t);
    teq_pkg::in_word_t w;
    w = teq_pkg::in_word_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                    $urandom}));
    w.op = op;
    w.now = t;
    return w;
  endfunction

  // Mostly small offsets so ticks release several events at once.
  task automatic random_word();
    int pick;
    pick = $urandom_range(99);
    clock_ms = clock_ms + TW'($urandom_range(40));
    if (pick < 60)
      send_word(rand_event(clock_ms, (pick < 5) ? 16'($urandom) : 16'($urandom_range(120))));
    else if (pick < 94) send_word(ctrl_word(teq_pkg::OP_TICK, clock_ms));
    else if (pick < 97) send_word(ctrl_word(teq_pkg::OP_CLEAR, clock_ms));
    else send_word(ctrl_word(OP_SPARE, clock_ms));
  endtask

  initial begin
    teq_pkg::in_word_t w;
    int hold_len;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, equal start times, saturation, empty tick, no position.
    send_word(ctrl_word(teq_pkg::OP_TICK, '0));
    w = rand_event('0, '0); w.has_position = 1'b0; w.pos_x = '1; send_word(w);
    w = rand_event('0, '0); w.has_position = 1'b1; w.emitter = '1; w.volume = 9'd256;
    w.pos_x = 24'h7FFFFF; w.pos_y = 24'h800000; w.pos_z = '1; w.attenuation = '1;
    send_word(w);
    w = rand_event('1, '1); send_word(w);
    w = rand_event(31'h7FFF0000, 16'hFFFF); send_word(w);
    w = rand_event(31'd100, 16'd5); send_word(w);
    w = rand_event(31'd100, 16'd5); w.channel_id = '1; w.sound_id = '1; send_word(w);
    w = rand_event(31'd50, 16'd0); send_word(w);
    send_word(ctrl_word(teq_pkg::OP_TICK, 31'd104));
    send_word(ctrl_word(teq_pkg::OP_TICK, 31'd105));
    send_word(ctrl_word(OP_SPARE, '1));
    send_word(ctrl_word(teq_pkg::OP_TICK, '1));
    // Fill the pool beyond capacity, then clear.
    for (int i = 0; i < POOL + 2; i++) send_word(rand_event(31'd10, 16'($urandom_range(30))));
    send_word(ctrl_word(teq_pkg::OP_CLEAR, '0));
    send_word(ctrl_word(teq_pkg::OP_TICK, '1));

    // Random phases with different idling.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 23 : 73) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 23 : 73) : 0;
      for (int k = 0; k < 40; k++) random_word();
    end

    // Long receiver hold-off while the sender keeps offering words.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        hold_len = 0;
        while (hold_len < 400) begin
          @(posedge clk);
          hold_len++;
        end
        hold_off = 1'b0;
      end
      begin
        for (int k = 0; k < 20; k++) begin
          send_word(rand_event(clock_ms, 16'd0));
          send_word(ctrl_word(teq_pkg::OP_TICK, clock_ms));
        end
        in_valid <= 1'b0;
      end
    join

    while (pending_results != 0) @(posedge clk);
    repeat (2 * POOL + 20) @(posedge clk);
    if (fail_count == 0 && pending_results == 0)
      $display("timed_event_queue verification clean");
    else
      $display("timed_event_queue verification failed");
    $finish;
  end
endmodule
